>>> hw/rtl/kms_pkg.sv
package kms_pkg;

  localparam int DATA_W  = 32;
  localparam int ANG_W   = 19;
  localparam int BND_W   = 16;
  localparam int ATH_W   = 18;
  localparam int K_W     = 16;
  localparam int QUO_W   = 17;
  localparam int FLAG_W  = 3;
  localparam int ADDR_W  = 5;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W   = $clog2(DIV_STEPS + 1);

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_PNOISE = 3'd0;
  localparam logic [2:0] REG_MNOISE = 3'd1;
  localparam logic [2:0] REG_IERR   = 3'd2;
  localparam logic [2:0] REG_XBND   = 3'd3;
  localparam logic [2:0] REG_YBND   = 3'd4;
  localparam logic [2:0] REG_ATHR   = 3'd5;
  localparam logic [2:0] REG_ACLMP  = 3'd6;

  // axis codes
  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_ROT = 2'd2;

  localparam logic [DATA_W-1:0] RST_PNOISE = 32'd65536;
  localparam logic [DATA_W-1:0] RST_MNOISE = 32'd65536;
  localparam logic [DATA_W-1:0] RST_IERR   = 32'd65536;
  localparam logic [BND_W-1:0]  RST_XBND   = 16'd19;
  localparam logic [BND_W-1:0]  RST_YBND   = 16'd10;
  localparam logic [ATH_W-1:0]  RST_ATHR   = 18'd5734;
  localparam logic [ATH_W-1:0]  RST_ACLMP  = 18'd5719;

  localparam logic [QUO_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [K_W-1:0]   K_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [DATA_W-1:0] process_noise;
    logic [DATA_W-1:0] measure_noise;
    logic [DATA_W-1:0] initial_error;
    logic [BND_W-1:0]  x_bound;
    logic [BND_W-1:0]  y_bound;
    logic [ATH_W-1:0]  angle_threshold;
    logic [ATH_W-1:0]  angle_clamp;
  } kms_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num_hi;
    logic [DATA_W:0]   den;
  } kms_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } kms_div_rsp_t;

endpackage

>>> hw/rtl/kms_if.sv
interface kms_in_if import kms_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] meas_dx;
  logic signed [DATA_W-1:0] meas_dy;
  logic signed [ANG_W-1:0]  meas_angle;
  logic                     meas_valid;
  logic                     restart;

  modport source (output valid, meas_dx, meas_dy, meas_angle, meas_valid, restart,
                  input ready);
  modport sink (input valid, meas_dx, meas_dy, meas_angle, meas_valid, restart,
                output ready);
endinterface

interface kms_out_if import kms_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filt_dx;
  logic signed [DATA_W-1:0] filt_dy;
  logic signed [ANG_W-1:0]  filt_angle;
  logic [FLAG_W-1:0]        clamp_flags;

  modport source (output valid, filt_dx, filt_dy, filt_angle, clamp_flags, input ready);
  modport sink (input valid, filt_dx, filt_dy, filt_angle, clamp_flags, output ready);
endinterface

>>> hw/rtl/kms_regs.sv
module kms_regs import kms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output kms_cfg_t          cfg
);

  kms_cfg_t   cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.process_noise   <= RST_PNOISE;
      cfg_r.measure_noise   <= RST_MNOISE;
      cfg_r.initial_error   <= RST_IERR;
      cfg_r.x_bound         <= RST_XBND;
      cfg_r.y_bound         <= RST_YBND;
      cfg_r.angle_threshold <= RST_ATHR;
      cfg_r.angle_clamp     <= RST_ACLMP;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_PNOISE: cfg_r.process_noise   <= pwdata;
        REG_MNOISE: cfg_r.measure_noise   <= pwdata;
        REG_IERR:   cfg_r.initial_error   <= pwdata;
        REG_XBND:   cfg_r.x_bound         <= pwdata[BND_W-1:0];
        REG_YBND:   cfg_r.y_bound         <= pwdata[BND_W-1:0];
        REG_ATHR:   cfg_r.angle_threshold <= pwdata[ATH_W-1:0];
        REG_ACLMP:  cfg_r.angle_clamp     <= pwdata[ATH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PNOISE: prdata = cfg_r.process_noise;
      REG_MNOISE: prdata = cfg_r.measure_noise;
      REG_IERR:   prdata = cfg_r.initial_error;
      REG_XBND:   prdata = {{(DATA_W-BND_W){1'b0}}, cfg_r.x_bound};
      REG_YBND:   prdata = {{(DATA_W-BND_W){1'b0}}, cfg_r.y_bound};
      REG_ATHR:   prdata = {{(DATA_W-ATH_W){1'b0}}, cfg_r.angle_threshold};
      REG_ACLMP:  prdata = {{(DATA_W-ATH_W){1'b0}}, cfg_r.angle_clamp};
      default:    prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/kms_div.sv
module kms_div import kms_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  kms_div_req_t req,
  output kms_div_rsp_t rsp
);

  // restoring divide of (num_hi << 16) by den, one quotient bit per cycle
  logic [DATA_W+1:0] rem_r;
  logic [DATA_W+1:0] rem_nxt;
  logic [DATA_W:0]   den_r;
  logic [QUO_W-1:0]  q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              dzero_r;
  logic [DATA_W+2:0] diff;
  logic              ge;
  logic [DATA_W+1:0] rem_sel;

  assign diff    = {1'b0, rem_r} - {2'b00, den_r};
  assign ge      = !diff[DATA_W+2];
  assign rem_sel = ge ? diff[DATA_W+1:0] : rem_r;
  // low dividend bits are all zero, so just shift
  assign rem_nxt = {rem_sel[DATA_W:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= CNT_W'(DIV_STEPS);
        rem_r   <= {2'b00, req.num_hi};
        den_r   <= req.den;
        dzero_r <= (req.den == '0);
        q_r     <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[QUO_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dzero_r ? '0 : q_r;

endmodule

>>> hw/rtl/kms_core.sv
module kms_core import kms_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  kms_cfg_t      cfg,
  kms_in_if.sink        in_ch,
  kms_out_if.source     out_ch,
  output kms_div_req_t  div_req,
  input  kms_div_rsp_t  div_rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_DSTART, S_DWAIT, S_MUL1, S_MUL2, S_FIN, S_DONE
  } state_t;

  state_t                   state_r;
  logic [1:0]               axis_r;
  logic [DATA_W-1:0]        err_r  [3];
  logic signed [DATA_W-1:0] prev_r [3];
  logic signed [DATA_W-1:0] meas_r [3];
  logic [DATA_W-1:0]        pp_r;
  logic signed [DATA_W:0]   d_r;
  logic [K_W-1:0]           k_r;
  logic signed [48:0]       prod_r;
  logic signed [DATA_W+1:0] fx_r;
  logic [FLAG_W-1:0]        flags_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_dx_r;
  logic signed [DATA_W-1:0] out_dy_r;
  logic signed [ANG_W-1:0]  out_ang_r;
  logic [FLAG_W-1:0]        out_flags_r;

  logic                     in_xfer;
  logic [DATA_W-1:0]        err_cur;
  logic signed [DATA_W-1:0] prev_cur;
  logic signed [DATA_W-1:0] meas_cur;
  logic [DATA_W:0]          pp_sum;
  logic [DATA_W-1:0]        pp_sat;
  logic signed [DATA_W:0]   d_nxt;
  logic [K_W-1:0]           k_sat;
  logic signed [DATA_W+1:0] mul_a;
  logic signed [QUO_W:0]    mul_b;
  logic signed [51:0]       mul_p;
  logic signed [49:0]       rnd;
  logic signed [DATA_W+1:0] fx_nxt;
  logic [DATA_W:0]          lim;
  logic [DATA_W:0]          rep;
  logic [DATA_W+1:0]        mag;
  logic                     hit;
  logic                     fx_pos;
  logic signed [DATA_W+1:0] fx_lim;
  logic signed [DATA_W-1:0] ang_ext;

  assign in_ch.ready = (state_r == S_IDLE) && rst_n;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign ang_ext     = {{(DATA_W-ANG_W){in_ch.meas_angle[ANG_W-1]}}, in_ch.meas_angle};

  assign err_cur  = err_r[axis_r];
  assign prev_cur = prev_r[axis_r];
  assign meas_cur = meas_r[axis_r];

  // predicted error, saturating
  assign pp_sum = {1'b0, err_cur} + {1'b0, cfg.process_noise};
  assign pp_sat = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
  assign d_nxt  = {meas_cur[DATA_W-1], meas_cur} - {prev_cur[DATA_W-1], prev_cur};

  assign div_req.start  = (state_r == S_DSTART);
  assign div_req.num_hi = pp_r;
  assign div_req.den    = {1'b0, pp_r} + {1'b0, cfg.measure_noise};

  assign k_sat = div_rsp.quot[QUO_W-1] ? K_MAX : div_rsp.quot[K_W-1:0];

  // shared multiplier: gain times innovation, then error times (1 - gain)
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = {d_r[DATA_W], d_r};
      mul_b = {2'b00, k_r};
    end else begin
      mul_a = {2'b00, pp_r};
      mul_b = {1'b0, ONE_Q16 - {1'b0, k_r}};
    end
  end
  assign mul_p = mul_a * mul_b;

  // round to nearest, ties up
  assign rnd    = {prod_r[48], prod_r} + 50'sd32768;
  assign fx_nxt = {{2{prev_cur[DATA_W-1]}}, prev_cur} + rnd[49:16];

  always_comb begin
    unique case (axis_r)
      AX_X: begin
        lim = {1'b0, cfg.x_bound, 16'd0};
        rep = lim;
      end
      AX_Y: begin
        lim = {1'b0, cfg.y_bound, 16'd0};
        rep = lim;
      end
      AX_ROT: begin
        lim = {{(DATA_W+1-ATH_W){1'b0}}, cfg.angle_threshold};
        rep = {{(DATA_W+1-ATH_W){1'b0}}, cfg.angle_clamp};
      end
      default: begin
        lim = '0;
        rep = '0;
      end
    endcase
  end

  assign mag    = fx_r[DATA_W+1] ? $unsigned(-fx_r) : $unsigned(fx_r);
  assign hit    = mag > {1'b0, lim};
  assign fx_pos = !fx_r[DATA_W+1] && (fx_r != '0);
  assign fx_lim = !hit ? fx_r :
                  fx_pos ? $signed({1'b0, rep}) : -$signed({1'b0, rep});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AX_X;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        err_r[i]  <= RST_IERR;
        prev_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.restart) begin
              for (int i = 0; i < 3; i++) begin
                err_r[i]  <= cfg.initial_error;
                prev_r[i] <= '0;
              end
            end
            if (in_ch.meas_valid) begin
              meas_r[0] <= in_ch.meas_dx;
              meas_r[1] <= in_ch.meas_dy;
              meas_r[2] <= ang_ext;
            end else begin
              for (int i = 0; i < 3; i++)
                meas_r[i] <= in_ch.restart ? '0 : prev_r[i];
            end
            axis_r  <= AX_X;
            flags_r <= '0;
            state_r <= S_PRED;
          end
        end
        S_PRED: begin
          pp_r    <= pp_sat;
          d_r     <= d_nxt;
          state_r <= S_DSTART;
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            k_r     <= k_sat;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_r  <= mul_p[48:0];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          fx_r    <= fx_nxt;
          prod_r  <= mul_p[48:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          err_r[axis_r]   <= prod_r[47:16];
          prev_r[axis_r]  <= fx_lim[DATA_W-1:0];
          flags_r[axis_r] <= hit;
          if (axis_r == AX_ROT) begin
            state_r <= S_DONE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_PRED;
          end
        end
        S_DONE: begin
          // wait for the previous result to be taken
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_dx_r    <= prev_r[0];
            out_dy_r    <= prev_r[1];
            out_ang_r   <= prev_r[2][ANG_W-1:0];
            out_flags_r <= flags_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.filt_dx     = out_dx_r;
  assign out_ch.filt_dy     = out_dy_r;
  assign out_ch.filt_angle  = out_ang_r;
  assign out_ch.clamp_flags = out_flags_r;

endmodule

>>> hw/rtl/motion_kalman_smoother_top.sv
// Motion smoother: one measured (dx, dy, angle) per frame goes through a scalar
// Kalman update per axis, then a clamp, and comes out as one filtered result.
// The three axes are handled one after another by the same hardware: a
// 17-step serial divider for the gain and one shared multiplier, so a result
// is registered only once all three axes are done, and the next input is
// taken only after that. The result sits in an output register, so a new
// input is taken while it still waits to be read. Values are Q16.16 with a
// Q0.16 gain. Register writes belong in idle time; initial_error is used
// only at reset and on a restart item.
module motion_kalman_smoother_top import kms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  kms_in_if.sink            in_item,
  kms_out_if.source         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  kms_cfg_t     cfg;
  kms_div_req_t div_req;
  kms_div_rsp_t div_rsp;

  kms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  kms_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_item),
    .out_ch  (out_item),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

endmodule

>>> hw/rtl/kms_check.sv
module kms_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);

  // a result stays offered until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // the block is busy right after taking an item
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while item in progress");

  // a new result only ever follows work in progress
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result with no item in progress");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port stalled");

endmodule

bind motion_kalman_smoother_top kms_check u_kms_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .pready    (pready)
);

>>> tb/sv/motion_kalman_smoother_top_tb.sv
module motion_kalman_smoother_top_tb;
  import kms_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_FRAMES  = 54;
  localparam int RANDOM_PHASES = 12;
  localparam int HOLD_CYCLES   = 600;
  localparam int ANG_MAX       = 205887;

  typedef struct {
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [ANG_W-1:0]  ang;
    logic                     meas_ok;
    logic                     restart;
  } motion_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [ANG_W-1:0]  ang;
    logic [FLAG_W-1:0]        flags;
  } filt_result_t;

  class motion_scoreboard;
    logic [DATA_W-1:0] q_noise, r_noise, p_init;
    logic [BND_W-1:0]  x_lim, y_lim;
    logic [ATH_W-1:0]  ang_thr, ang_clamp;
    longint            last_x, last_y, last_rot;
    logic [DATA_W-1:0] p_x, p_y, p_rot;
    filt_result_t      expected_q[$];
    int unsigned       frames, results, restarts, coasts, mismatches;
    int unsigned       clamp_cnt[3];

    function new();
      q_noise   = RST_PNOISE;
      r_noise   = RST_MNOISE;
      p_init    = RST_IERR;
      x_lim     = RST_XBND;
      y_lim     = RST_YBND;
      ang_thr   = RST_ATHR;
      ang_clamp = RST_ACLMP;
      last_x    = 0;
      last_y    = 0;
      last_rot  = 0;
      p_x       = RST_IERR;
      p_y       = RST_IERR;
      p_rot     = RST_IERR;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_PNOISE: q_noise   = val;
        REG_MNOISE: r_noise   = val;
        REG_IERR:   p_init    = val;
        REG_XBND:   x_lim     = val[BND_W-1:0];
        REG_YBND:   y_lim     = val[BND_W-1:0];
        REG_ATHR:   ang_thr   = val[ATH_W-1:0];
        REG_ACLMP:  ang_clamp = val[ATH_W-1:0];
        default: ;
      endcase
    endfunction

    // one scalar kalman step, gain in q0.16, estimate rounded half up
    function longint axis_update(longint prev, longint meas, inout logic [DATA_W-1:0] p);
      longint unsigned pp, den, gain;
      longint          acc;
      pp = 64'(p) + 64'(q_noise);
      if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
      den  = pp + 64'(r_noise);
      gain = (den == 0) ? 64'd0 : (pp << 16) / den;
      if (gain > 64'd65535) gain = 64'd65535;
      acc = longint'(gain) * (meas - prev) + 32768;
      p   = DATA_W'((pp * (64'd65536 - gain)) >> 16);
      return prev + (acc >>> 16);
    endfunction

    function longint clamp_to(longint v, longint lim, longint rep, output logic hit);
      longint mag;
      mag = (v < 0) ? -v : v;
      hit = mag > lim;
      if (!hit) return v;
      return (v > 0) ? rep : -rep;
    endfunction

    function void note_input(motion_item_t it);
      longint       mx, my, ma, fx, fy, fa;
      logic         hx, hy, ha;
      filt_result_t r;
      frames++;
      if (it.restart) begin
        restarts++;
        p_x      = p_init;
        p_y      = p_init;
        p_rot    = p_init;
        last_x   = 0;
        last_y   = 0;
        last_rot = 0;
      end
      if (it.meas_ok) begin
        mx = longint'(it.dx);
        my = longint'(it.dy);
        ma = longint'(it.ang);
      end else begin
        coasts++;
        mx = last_x;
        my = last_y;
        ma = last_rot;
      end
      fx = axis_update(last_x, mx, p_x);
      fy = axis_update(last_y, my, p_y);
      fa = axis_update(last_rot, ma, p_rot);
      fx = clamp_to(fx, longint'(x_lim) * 65536, longint'(x_lim) * 65536, hx);
      fy = clamp_to(fy, longint'(y_lim) * 65536, longint'(y_lim) * 65536, hy);
      fa = clamp_to(fa, longint'(ang_thr), longint'(ang_clamp), ha);
      last_x   = fx;
      last_y   = fy;
      last_rot = fa;
      r.dx    = fx[DATA_W-1:0];
      r.dy    = fy[DATA_W-1:0];
      r.ang   = fa[ANG_W-1:0];
      r.flags = {ha, hy, hx};
      if (hx) clamp_cnt[0]++;
      if (hy) clamp_cnt[1]++;
      if (ha) clamp_cnt[2]++;
      expected_q = {expected_q, r};
    endfunction

    function void check_result(filt_result_t got);
      filt_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with no frame outstanding: dx=%h dy=%h angle=%h flags=%b",
                   results, got.dx, got.dy, got.ang, got.flags);
        return;
      end
      want = expected_q.pop_front();
      if (got.dx !== want.dx || got.dy !== want.dy || got.ang !== want.ang ||
          got.flags !== want.flags) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d expected dx=%h dy=%h angle=%h flags=%b", results,
                   want.dx, want.dy, want.ang, want.flags);
          $display("result %0d actual   dx=%h dy=%h angle=%h flags=%b", results,
                   got.dx, got.dy, got.ang, got.flags);
        end
      end
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        $display("%0d frames never produced a result", expected_q.size());
        mismatches += expected_q.size();
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              hold_off;
  int                send_idle_pct, recv_idle_pct;
  int                stall_cycles;
  int unsigned       settings_used;

  motion_scoreboard sb;

  kms_in_if  in_if();
  kms_out_if out_if();

  motion_kalman_smoother_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // input side noted before the result side, so a frame is queued before any check
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_input('{in_if.meas_dx, in_if.meas_dy, in_if.meas_angle,
                      in_if.meas_valid, in_if.restart});
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result('{out_if.filt_dx, out_if.filt_dy, out_if.filt_angle,
                        out_if.clamp_flags});
  end

  always @(posedge clk) begin
    out_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [DATA_W-1:0] pn, logic [DATA_W-1:0] mn,
                              logic [DATA_W-1:0] ie, logic [DATA_W-1:0] xb,
                              logic [DATA_W-1:0] yb, logic [DATA_W-1:0] th,
                              logic [DATA_W-1:0] cl);
    reg_write(REG_PNOISE, pn);
    reg_write(REG_MNOISE, mn);
    reg_write(REG_IERR, ie);
    reg_write(REG_XBND, xb);
    reg_write(REG_YBND, yb);
    reg_write(REG_ATHR, th);
    reg_write(REG_ACLMP, cl);
    settings_used++;
  endtask

  task automatic send_item(motion_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.meas_dx    <= it.dx;
    in_if.meas_dy    <= it.dy;
    in_if.meas_angle <= it.ang;
    in_if.meas_valid <= it.meas_ok;
    in_if.restart    <= it.restart;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic motion_item_t meas_item(logic [DATA_W-1:0] dx, logic [DATA_W-1:0] dy,
                                             int ang, bit ok, bit rs);
    motion_item_t it;
    it.dx      = dx;
    it.dy      = dy;
    it.ang     = ANG_W'(ang);
    it.meas_ok = ok;
    it.restart = rs;
    return it;
  endfunction

  // shifts spread a couple of pixels past the bound on either side
  function automatic logic [DATA_W-1:0] around_bound(logic [BND_W-1:0] bnd);
    longint span;
    span = (longint'(bnd) + 2) * 65536;
    if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
    return DATA_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
  endfunction

  function automatic motion_item_t random_item();
    motion_item_t it;
    int unsigned  shape;
    longint       span, ang;
    shape = $urandom_range(9);
    if (shape < 2) begin
      it.dx = $urandom;
      it.dy = $urandom;
    end else if (shape < 7) begin
      it.dx = around_bound(sb.x_lim);
      it.dy = around_bound(sb.y_lim);
    end else begin
      it.dx = DATA_W'($signed(20'($urandom)));
      it.dy = DATA_W'($signed(20'($urandom)));
    end
    if ($urandom_range(1) == 0) begin
      ang = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
    end else begin
      span = 2 * longint'(sb.ang_thr) + 16;
      if (span > ANG_MAX) span = ANG_MAX;
      ang = longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    it.ang     = ANG_W'(ang);
    it.meas_ok = $urandom_range(99) < 85;
    it.restart = $urandom_range(99) < 4;
    return it;
  endfunction

  initial begin
    logic [DATA_W-1:0] pn, mn, ie, xb, yb, th, cl;
    motion_item_t      it;
    sb = new();
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    hold_off         <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.meas_dx    <= '0;
    in_if.meas_dy    <= '0;
    in_if.meas_angle <= '0;
    in_if.meas_valid <= 1'b0;
    in_if.restart    <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 69;
    settings_used = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: extremes, coasting frames, restarts, rounding ties
    send_item(meas_item(32'h7FFF_FFFF, 32'h8000_0000, ANG_MAX, 1, 0));
    send_item(meas_item(32'h8000_0000, 32'h7FFF_FFFF, -ANG_MAX, 1, 0));
    send_item(meas_item(32'h0, 32'h0, 0, 1, 0));
    send_item(meas_item(32'h0003_8000, 32'hFFFE_8000, 4000, 1, 0));
    send_item(meas_item(32'h1234_5678, 32'h8765_4321, 1234, 0, 0));
    send_item(meas_item(32'hFFFF_FFFF, 32'h0000_0001, -1, 1, 0));
    send_item(meas_item(32'h0013_0000, 32'hFFF6_0000, 5734, 1, 1));
    send_item(meas_item(32'h5555_5555, 32'hAAAA_AAAA, 174762, 1, 0));
    send_item(meas_item(32'hDEAD_BEEF, 32'h0BAD_F00D, 777, 0, 1));
    send_item(meas_item(32'h00FF_0000, 32'hFF00_0000, -5735, 1, 0));
    wait_drained();

    // no measurement noise: gain pinned at its maximum
    reg_write(REG_MNOISE, 32'h0);
    settings_used++;
    send_item(meas_item(32'h0005_0000, 32'hFFFD_0000, 3000, 1, 1));
    send_item(meas_item(32'h7FFF_FFFF, 32'h8000_0000, -ANG_MAX, 1, 0));
    send_item(meas_item(32'h0, 32'h0, 0, 0, 0));
    wait_drained();

    // zero error and no noise at all: gain denominator is zero
    reg_write(REG_PNOISE, 32'h0);
    reg_write(REG_IERR, 32'h0);
    settings_used++;
    send_item(meas_item(32'h0004_0000, 32'hFFFC_0000, 2000, 1, 1));
    send_item(meas_item(32'h8000_0000, 32'h7FFF_FFFF, ANG_MAX, 1, 0));
    send_item(meas_item(32'h0001_0000, 32'h0001_0000, 100, 0, 0));
    wait_drained();

    // top of the noise, error and x/y bound ranges, angle limits at ANG_MAX; error prediction saturates
    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
                 32'h0000_FFFF, ANG_MAX, ANG_MAX);
    send_item(meas_item(32'h7FFF_FFFF, 32'h8000_0000, ANG_MAX, 1, 1));
    send_item(meas_item(32'h8000_0000, 32'h7FFF_FFFF, -ANG_MAX, 1, 0));
    send_item(meas_item(32'h8000_0000, 32'h8000_0000, -ANG_MAX, 1, 0));
    send_item(meas_item(32'h0, 32'h0, 0, 0, 0));
    send_item(meas_item(32'h0, 32'h0, 0, 1, 0));
    wait_drained();

    // zero bounds clamp everything but an exact zero
    apply_config(32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(meas_item(32'h0002_0000, 32'hFFFE_0000, 1, 1, 1));
    send_item(meas_item(32'hFFFF_FFFF, 32'h0000_0001, -1, 1, 0));
    send_item(meas_item(32'h0, 32'h0, 0, 1, 0));
    send_item(meas_item(32'h4000_0000, 32'hC000_0000, 65536, 0, 0));
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 16;
      end else if (ph == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pn = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
      mn = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000);
      if (mn == 0) mn = 1;
      ie = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
      xb = ($urandom_range(4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      yb = ($urandom_range(4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      th = $urandom_range(0, ANG_MAX);
      cl = $urandom_range(0, ANG_MAX);
      // junk above each register's width must be dropped
      apply_config(pn, mn, ie, {16'($urandom), xb[15:0]}, {16'($urandom), yb[15:0]},
                   {14'($urandom), th[17:0]}, {14'($urandom), cl[17:0]});
      if (ph == 2 * RANDOM_PHASES / 3 + 1) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        it = random_item();
        if (n == 0) it.restart = $urandom_range(1);
        send_item(it);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    sb.report_leftover();
    $display("covered %0d frames over %0d register settings, %0d restarts, %0d coasting",
             sb.frames, settings_used, sb.restarts, sb.coasts);
    $display("clamped results x/y/angle: %0d/%0d/%0d, errors: %0d",
             sb.clamp_cnt[0], sb.clamp_cnt[1], sb.clamp_cnt[2], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
